[src/taf_pkg.sv]
package taf_pkg;

    localparam int COORD_WIDTH         = 16;
    localparam int TRIG_FRACTION_BITS  = 14;
    localparam int SCALE_FRACTION_BITS = 12;
    localparam int SCALE_WIDTH         = 16;
    localparam int ANGLE_WIDTH         = 9;
    localparam int NUM_LANES           = 3;

    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = (COORD_WIDTH > SCALE_WIDTH) ? COORD_WIDTH : SCALE_WIDTH;

    // Angles in whole degrees.
    localparam int QUARTER_TURN = 90;
    localparam int HALF_TURN    = 180;
    localparam int THREE_QUARTER_TURN = 270;
    localparam int FULL_TURN    = 360;

    // Sine magnitude 0..1.0 needs one bit above the fraction; signed values one more.
    localparam int TABLE_WIDTH = TRIG_FRACTION_BITS + 1;
    localparam int TRIG_WIDTH  = TRIG_FRACTION_BITS + 2;
    localparam int TABLE_INDEX_WIDTH = $clog2(QUARTER_TURN + 1);

    // Datapath widths inside a lane.
    localparam int DIFF_WIDTH  = COORD_WIDTH + 1;
    localparam int COEF_WIDTH  = (TRIG_WIDTH > SCALE_WIDTH + 1) ? TRIG_WIDTH : SCALE_WIDTH + 1;
    localparam int PROD_WIDTH  = DIFF_WIDTH + COEF_WIDTH;
    localparam int FRAC_MAX    = (TRIG_FRACTION_BITS > SCALE_FRACTION_BITS) ?
                                 TRIG_FRACTION_BITS : SCALE_FRACTION_BITS;
    localparam int SUM_WIDTH   = ((PROD_WIDTH > COORD_WIDTH + FRAC_MAX) ?
                                  PROD_WIDTH : COORD_WIDTH + FRAC_MAX) + 2;

    localparam longint unsigned PI_Q30 = 64'd3373259426;
    localparam int SINE_TERMS = 10;

    // Divisor of series term k, (2k)(2k+1).
    localparam longint unsigned SERIES_DIV [1:SINE_TERMS] =
        '{64'd6, 64'd20, 64'd42, 64'd72, 64'd110,
          64'd156, 64'd210, 64'd272, 64'd342, 64'd420};

    typedef enum logic [1:0] {
        OP_TRANSLATE = 2'd0,
        OP_ROTATE    = 2'd1,
        OP_SCALE     = 2'd2,
        OP_PASS      = 2'd3
    } t_opcode;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_SHIFT_X = 3'd0,
        REG_SHIFT_Y = 3'd1,
        REG_ANGLE   = 3'd2,
        REG_PIVOT_X = 3'd3,
        REG_PIVOT_Y = 3'd4,
        REG_SCALE_X = 3'd5,
        REG_SCALE_Y = 3'd6
    } t_reg_index;

    typedef struct packed {
        t_opcode                        opcode;
        logic signed [COORD_WIDTH-1:0] vertex_a_x;
        logic signed [COORD_WIDTH-1:0] vertex_a_y;
        logic signed [COORD_WIDTH-1:0] vertex_b_x;
        logic signed [COORD_WIDTH-1:0] vertex_b_y;
        logic signed [COORD_WIDTH-1:0] vertex_c_x;
        logic signed [COORD_WIDTH-1:0] vertex_c_y;
    } t_in_payload;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] out_a_x;
        logic signed [COORD_WIDTH-1:0] out_a_y;
        logic signed [COORD_WIDTH-1:0] out_b_x;
        logic signed [COORD_WIDTH-1:0] out_b_y;
        logic signed [COORD_WIDTH-1:0] out_c_x;
        logic signed [COORD_WIDTH-1:0] out_c_y;
        logic                           saturated;
    } t_out_payload;

    typedef struct packed {
        logic signed [COORD_WIDTH-1:0] shift_x;
        logic signed [COORD_WIDTH-1:0] shift_y;
        logic signed [COORD_WIDTH-1:0] pivot_x;
        logic signed [COORD_WIDTH-1:0] pivot_y;
        logic [SCALE_WIDTH-1:0]        scale_x;
        logic [SCALE_WIDTH-1:0]        scale_y;
    } t_lane_cfg;

    typedef struct packed {
        logic en_a;
        logic en_b;
        logic en_c;
        logic en_d;
    } t_lane_ctrl;

    typedef logic [TABLE_WIDTH-1:0] t_sine_table [0:QUARTER_TURN];

    // Quarter-wave sine, built at elaboration from a Taylor series in Q2.30
    // and rounded half up to the trig fraction.
    function automatic t_sine_table build_sine_table();
        t_sine_table      tab;
        longint unsigned  x;
        longint unsigned  x2;
        longint unsigned  term;
        longint           sum;
        for (int d = 0; d <= QUARTER_TURN; d++) begin
            x    = (longint'(d) * PI_Q30 + 64'd90) / HALF_TURN;
            x2   = (x * x) >> 30;
            term = x;
            sum  = longint'(x);
            for (int k = 1; k <= SINE_TERMS; k++) begin
                term = ((term * x2) >> 30) / SERIES_DIV[k];
                if (k % 2 == 1) begin
                    sum = sum - longint'(term);
                end else begin
                    sum = sum + longint'(term);
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            if (sum > (64'sd1 <<< 30)) begin
                sum = 64'sd1 <<< 30;
            end
            tab[d] = TABLE_WIDTH'((sum + (64'sd1 <<< (29 - TRIG_FRACTION_BITS)))
                                  >>> (30 - TRIG_FRACTION_BITS));
        end
        return tab;
    endfunction

    localparam t_sine_table SINE_TABLE = build_sine_table();

endpackage

[src/taf_if.sv]
interface taf_in_if import taf_pkg::*; ();
    logic        valid;
    logic        ready;
    t_in_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface taf_out_if import taf_pkg::*; ();
    logic         valid;
    logic         ready;
    t_out_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[src/taf_trig.sv]
module taf_trig import taf_pkg::*; (
    input  logic [ANGLE_WIDTH-1:0]        i_angle,
    output logic signed [TRIG_WIDTH-1:0]  o_sin,
    output logic signed [TRIG_WIDTH-1:0]  o_cos
);

    logic [ANGLE_WIDTH-1:0]       w_deg;
    logic [ANGLE_WIDTH-1:0]       w_diff_s;
    logic [ANGLE_WIDTH-1:0]       w_diff_c;
    logic [TABLE_INDEX_WIDTH-1:0] w_idx_s;
    logic [TABLE_INDEX_WIDTH-1:0] w_idx_c;
    logic                         w_neg_s;
    logic                         w_neg_c;
    logic [TRIG_WIDTH-1:0]        w_mag_s;
    logic [TRIG_WIDTH-1:0]        w_mag_c;

    // Angles past a full turn wrap once; the register cannot hold two turns.
    assign w_deg = (i_angle >= ANGLE_WIDTH'(FULL_TURN)) ?
                   i_angle - ANGLE_WIDTH'(FULL_TURN) : i_angle;

    always_comb begin
        if (w_deg < ANGLE_WIDTH'(QUARTER_TURN)) begin
            w_diff_s = w_deg;
            w_diff_c = ANGLE_WIDTH'(QUARTER_TURN) - w_deg;
            w_neg_s  = 1'b0;
            w_neg_c  = 1'b0;
        end else if (w_deg < ANGLE_WIDTH'(HALF_TURN)) begin
            w_diff_s = ANGLE_WIDTH'(HALF_TURN) - w_deg;
            w_diff_c = w_deg - ANGLE_WIDTH'(QUARTER_TURN);
            w_neg_s  = 1'b0;
            w_neg_c  = 1'b1;
        end else if (w_deg < ANGLE_WIDTH'(THREE_QUARTER_TURN)) begin
            w_diff_s = w_deg - ANGLE_WIDTH'(HALF_TURN);
            w_diff_c = ANGLE_WIDTH'(THREE_QUARTER_TURN) - w_deg;
            w_neg_s  = 1'b1;
            w_neg_c  = 1'b1;
        end else begin
            w_diff_s = ANGLE_WIDTH'(FULL_TURN) - w_deg;
            w_diff_c = w_deg - ANGLE_WIDTH'(THREE_QUARTER_TURN);
            w_neg_s  = 1'b1;
            w_neg_c  = 1'b0;
        end
    end

    assign w_idx_s = w_diff_s[TABLE_INDEX_WIDTH-1:0];
    assign w_idx_c = w_diff_c[TABLE_INDEX_WIDTH-1:0];
    assign w_mag_s = TRIG_WIDTH'(SINE_TABLE[w_idx_s]);
    assign w_mag_c = TRIG_WIDTH'(SINE_TABLE[w_idx_c]);

    assign o_sin = w_neg_s ? -signed'(w_mag_s) : signed'(w_mag_s);
    assign o_cos = w_neg_c ? -signed'(w_mag_c) : signed'(w_mag_c);

endmodule

[src/taf_lane.sv]
module taf_lane import taf_pkg::*; (
    input  logic                           i_clk,
    input  t_lane_ctrl                     i_ctrl,
    input  t_lane_cfg                      i_cfg,
    input  t_opcode                        i_op,
    input  logic signed [COORD_WIDTH-1:0]  i_x,
    input  logic signed [COORD_WIDTH-1:0]  i_y,
    input  logic signed [TRIG_WIDTH-1:0]   i_sin,
    input  logic signed [TRIG_WIDTH-1:0]   i_cos,
    output logic signed [COORD_WIDTH-1:0]  o_x,
    output logic signed [COORD_WIDTH-1:0]  o_y,
    output logic                           o_sat
);

    localparam logic signed [SUM_WIDTH-1:0] C_MAX =
        SUM_WIDTH'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [SUM_WIDTH-1:0] C_MIN = -C_MAX - SUM_WIDTH'(1);
    localparam logic signed [SUM_WIDTH-1:0] ROT_BIAS =
        SUM_WIDTH'((64'sd1 <<< TRIG_FRACTION_BITS) - 64'sd1);
    localparam logic signed [SUM_WIDTH-1:0] SCL_BIAS =
        SUM_WIDTH'((64'sd1 <<< SCALE_FRACTION_BITS) - 64'sd1);
    localparam logic signed [SUM_WIDTH-1:0] SUM_ZERO = '0;

    // Stage A: differences to the pivot.
    t_opcode                        r_a_op;
    logic signed [COORD_WIDTH-1:0]  r_a_x;
    logic signed [COORD_WIDTH-1:0]  r_a_y;
    logic signed [DIFF_WIDTH-1:0]   r_a_dx;
    logic signed [DIFF_WIDTH-1:0]   r_a_dy;
    logic signed [DIFF_WIDTH-1:0]   n_a_dx;
    logic signed [DIFF_WIDTH-1:0]   n_a_dy;

    // Stage B: products.
    t_opcode                        r_b_op;
    logic signed [COORD_WIDTH-1:0]  r_b_x;
    logic signed [COORD_WIDTH-1:0]  r_b_y;
    logic signed [PROD_WIDTH-1:0]   r_b_px1;
    logic signed [PROD_WIDTH-1:0]   r_b_px2;
    logic signed [PROD_WIDTH-1:0]   r_b_py1;
    logic signed [PROD_WIDTH-1:0]   r_b_py2;
    logic signed [COEF_WIDTH-1:0]   w_kx1;
    logic signed [COEF_WIDTH-1:0]   w_kx2;
    logic signed [COEF_WIDTH-1:0]   w_ky1;
    logic signed [COEF_WIDTH-1:0]   w_ky2;

    // Stage C: sums in fixed point.
    t_opcode                        r_c_op;
    logic signed [SUM_WIDTH-1:0]    r_c_x;
    logic signed [SUM_WIDTH-1:0]    r_c_y;
    logic signed [SUM_WIDTH-1:0]    n_c_x;
    logic signed [SUM_WIDTH-1:0]    n_c_y;
    logic signed [SUM_WIDTH-1:0]    w_piv_x;
    logic signed [SUM_WIDTH-1:0]    w_piv_y;

    // Stage D: truncated, clamped result.
    logic signed [COORD_WIDTH-1:0]  r_d_x;
    logic signed [COORD_WIDTH-1:0]  r_d_y;
    logic                           r_d_sat;
    logic signed [COORD_WIDTH-1:0]  n_d_x;
    logic signed [COORD_WIDTH-1:0]  n_d_y;
    logic                           n_d_sat;
    logic                           w_sat_x;
    logic                           w_sat_y;

    function automatic logic signed [SUM_WIDTH-1:0] trunc_frac(
        input logic signed [SUM_WIDTH-1:0] v,
        input t_opcode                     op
    );
        logic signed [SUM_WIDTH-1:0] res;
        // Negative values get a bias so the shift rounds toward zero.
        case (op)
            OP_ROTATE: res = (v + (v[SUM_WIDTH-1] ? ROT_BIAS : SUM_ZERO))
                             >>> TRIG_FRACTION_BITS;
            OP_SCALE:  res = (v + (v[SUM_WIDTH-1] ? SCL_BIAS : SUM_ZERO))
                             >>> SCALE_FRACTION_BITS;
            default:   res = v;
        endcase
        return res;
    endfunction

    assign n_a_dx = DIFF_WIDTH'(i_x) - DIFF_WIDTH'(i_cfg.pivot_x);
    assign n_a_dy = DIFF_WIDTH'(i_y) - DIFF_WIDTH'(i_cfg.pivot_y);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_a) begin
            r_a_op <= i_op;
            r_a_x  <= i_x;
            r_a_y  <= i_y;
            r_a_dx <= n_a_dx;
            r_a_dy <= n_a_dy;
        end
    end

    // Rotation uses both products per coordinate; scaling only the first.
    always_comb begin
        if (r_a_op == OP_ROTATE) begin
            w_kx1 = COEF_WIDTH'(i_cos);
            w_kx2 = COEF_WIDTH'(i_sin);
            w_ky1 = COEF_WIDTH'(i_cos);
            w_ky2 = COEF_WIDTH'(i_sin);
        end else begin
            w_kx1 = signed'(COEF_WIDTH'(i_cfg.scale_x));
            w_kx2 = '0;
            w_ky1 = signed'(COEF_WIDTH'(i_cfg.scale_y));
            w_ky2 = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_b) begin
            r_b_op  <= r_a_op;
            r_b_x   <= r_a_x;
            r_b_y   <= r_a_y;
            r_b_px1 <= r_a_dx * w_kx1;
            r_b_px2 <= r_a_dy * w_kx2;
            r_b_py1 <= r_a_dy * w_ky1;
            r_b_py2 <= r_a_dx * w_ky2;
        end
    end

    assign w_piv_x = SUM_WIDTH'(i_cfg.pivot_x);
    assign w_piv_y = SUM_WIDTH'(i_cfg.pivot_y);

    always_comb begin
        case (r_b_op)
            OP_TRANSLATE: begin
                n_c_x = SUM_WIDTH'(r_b_x) + SUM_WIDTH'(i_cfg.shift_x);
                n_c_y = SUM_WIDTH'(r_b_y) + SUM_WIDTH'(i_cfg.shift_y);
            end
            OP_ROTATE: begin
                n_c_x = (w_piv_x <<< TRIG_FRACTION_BITS) + SUM_WIDTH'(r_b_px1)
                        - SUM_WIDTH'(r_b_px2);
                n_c_y = (w_piv_y <<< TRIG_FRACTION_BITS) + SUM_WIDTH'(r_b_py1)
                        + SUM_WIDTH'(r_b_py2);
            end
            OP_SCALE: begin
                n_c_x = (w_piv_x <<< SCALE_FRACTION_BITS) + SUM_WIDTH'(r_b_px1);
                n_c_y = (w_piv_y <<< SCALE_FRACTION_BITS) + SUM_WIDTH'(r_b_py1);
            end
            default: begin
                n_c_x = SUM_WIDTH'(r_b_x);
                n_c_y = SUM_WIDTH'(r_b_y);
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_c) begin
            r_c_op <= r_b_op;
            r_c_x  <= n_c_x;
            r_c_y  <= n_c_y;
        end
    end

    always_comb begin
        logic signed [SUM_WIDTH-1:0] q_x;
        logic signed [SUM_WIDTH-1:0] q_y;
        q_x = trunc_frac(r_c_x, r_c_op);
        q_y = trunc_frac(r_c_y, r_c_op);
        w_sat_x = (q_x > C_MAX) || (q_x < C_MIN);
        w_sat_y = (q_y > C_MAX) || (q_y < C_MIN);
        if (q_x > C_MAX) begin
            n_d_x = COORD_WIDTH'(C_MAX);
        end else if (q_x < C_MIN) begin
            n_d_x = COORD_WIDTH'(C_MIN);
        end else begin
            n_d_x = COORD_WIDTH'(q_x);
        end
        if (q_y > C_MAX) begin
            n_d_y = COORD_WIDTH'(C_MAX);
        end else if (q_y < C_MIN) begin
            n_d_y = COORD_WIDTH'(C_MIN);
        end else begin
            n_d_y = COORD_WIDTH'(q_y);
        end
        n_d_sat = w_sat_x || w_sat_y;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.en_d) begin
            r_d_x   <= n_d_x;
            r_d_y   <= n_d_y;
            r_d_sat <= n_d_sat;
        end
    end

    assign o_x   = r_d_x;
    assign o_y   = r_d_y;
    assign o_sat = r_d_sat;

endmodule

[src/triangle_affine_transform_top.sv]
// Transforms one triangle per request: translate by the shift registers, rotate
// about the pivot by a whole-degree angle, scale about the pivot by Q4.12
// factors or pass it unchanged, with each coordinate truncated toward zero and
// clamped to the coordinate range. Three vertex lanes run side by side through a
// four-stage pipeline (pivot difference, multiply, sum, truncate and clamp), so a
// new request is taken every cycle while backpressure does not stall the pipeline;
// the last stage is the output register and the saturated flag merges the clamp
// flags of all lanes. Backpressure stalls only the stages that are full. Sine and
// cosine come from a 91-entry quarter-wave table.
// Configuration registers are to be written only while no request is in flight.
module triangle_affine_transform_top import taf_pkg::*; (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    taf_in_if.sink                      i_req,
    taf_out_if.source                   o_res,
    input  logic                        i_cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]  i_cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]   i_cfg_data
);

    t_lane_cfg                      r_cfg;
    logic [ANGLE_WIDTH-1:0]         r_angle;

    logic                           r_vld_a;
    logic                           r_vld_b;
    logic                           r_vld_c;
    logic                           r_vld_d;
    logic                           w_rdy_a;
    logic                           w_rdy_b;
    logic                           w_rdy_c;
    logic                           w_rdy_d;
    t_lane_ctrl                     w_ctrl;

    logic signed [TRIG_WIDTH-1:0]   w_sin;
    logic signed [TRIG_WIDTH-1:0]   w_cos;
    logic signed [TRIG_WIDTH-1:0]   r_a_sin;
    logic signed [TRIG_WIDTH-1:0]   r_a_cos;

    logic signed [COORD_WIDTH-1:0]  w_x   [NUM_LANES];
    logic signed [COORD_WIDTH-1:0]  w_y   [NUM_LANES];
    logic signed [COORD_WIDTH-1:0]  w_ox  [NUM_LANES];
    logic signed [COORD_WIDTH-1:0]  w_oy  [NUM_LANES];
    logic [NUM_LANES-1:0]           w_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.shift_x <= '0;
            r_cfg.shift_y <= '0;
            r_cfg.pivot_x <= '0;
            r_cfg.pivot_y <= '0;
            r_cfg.scale_x <= SCALE_WIDTH'(1 << SCALE_FRACTION_BITS);
            r_cfg.scale_y <= SCALE_WIDTH'(1 << SCALE_FRACTION_BITS);
            r_angle       <= '0;
        end else if (i_cfg_we) begin
            unique case (t_reg_index'(i_cfg_index))
                REG_SHIFT_X: r_cfg.shift_x <= signed'(i_cfg_data[COORD_WIDTH-1:0]);
                REG_SHIFT_Y: r_cfg.shift_y <= signed'(i_cfg_data[COORD_WIDTH-1:0]);
                REG_ANGLE:   r_angle       <= i_cfg_data[ANGLE_WIDTH-1:0];
                REG_PIVOT_X: r_cfg.pivot_x <= signed'(i_cfg_data[COORD_WIDTH-1:0]);
                REG_PIVOT_Y: r_cfg.pivot_y <= signed'(i_cfg_data[COORD_WIDTH-1:0]);
                REG_SCALE_X: r_cfg.scale_x <= i_cfg_data[SCALE_WIDTH-1:0];
                REG_SCALE_Y: r_cfg.scale_y <= i_cfg_data[SCALE_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    // A stage may load whenever it is empty or its content moves on.
    assign w_rdy_d = !r_vld_d || o_res.ready;
    assign w_rdy_c = !r_vld_c || w_rdy_d;
    assign w_rdy_b = !r_vld_b || w_rdy_c;
    assign w_rdy_a = !r_vld_a || w_rdy_b;

    assign w_ctrl.en_a = w_rdy_a && i_req.valid;
    assign w_ctrl.en_b = w_rdy_b && r_vld_a;
    assign w_ctrl.en_c = w_rdy_c && r_vld_b;
    assign w_ctrl.en_d = w_rdy_d && r_vld_c;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld_a <= 1'b0;
            r_vld_b <= 1'b0;
            r_vld_c <= 1'b0;
            r_vld_d <= 1'b0;
        end else begin
            if (w_rdy_a) begin
                r_vld_a <= i_req.valid;
            end
            if (w_rdy_b) begin
                r_vld_b <= r_vld_a;
            end
            if (w_rdy_c) begin
                r_vld_c <= r_vld_b;
            end
            if (w_rdy_d) begin
                r_vld_d <= r_vld_c;
            end
        end
    end

    taf_trig u_trig (
        .i_angle (r_angle),
        .o_sin   (w_sin),
        .o_cos   (w_cos)
    );

    always_ff @(posedge i_clk) begin
        if (w_ctrl.en_a) begin
            r_a_sin <= w_sin;
            r_a_cos <= w_cos;
        end
    end

    assign w_x[0] = i_req.data.vertex_a_x;
    assign w_y[0] = i_req.data.vertex_a_y;
    assign w_x[1] = i_req.data.vertex_b_x;
    assign w_y[1] = i_req.data.vertex_b_y;
    assign w_x[2] = i_req.data.vertex_c_x;
    assign w_y[2] = i_req.data.vertex_c_y;

    for (genvar g = 0; g < NUM_LANES; g++) begin : g_lane
        taf_lane u_lane (
            .i_clk  (i_clk),
            .i_ctrl (w_ctrl),
            .i_cfg  (r_cfg),
            .i_op   (i_req.data.opcode),
            .i_x    (w_x[g]),
            .i_y    (w_y[g]),
            .i_sin  (r_a_sin),
            .i_cos  (r_a_cos),
            .o_x    (w_ox[g]),
            .o_y    (w_oy[g]),
            .o_sat  (w_sat[g])
        );
    end

    assign i_req.ready = w_rdy_a;

    assign o_res.valid          = r_vld_d;
    assign o_res.data.out_a_x   = w_ox[0];
    assign o_res.data.out_a_y   = w_oy[0];
    assign o_res.data.out_b_x   = w_ox[1];
    assign o_res.data.out_b_y   = w_oy[1];
    assign o_res.data.out_c_x   = w_ox[2];
    assign o_res.data.out_c_y   = w_oy[2];
    assign o_res.data.saturated = |w_sat;

endmodule

[tb/tb_triangle_affine_transform_top.sv]
`timescale 1ns / 100ps

module tb_triangle_affine_transform_top;
    import taf_pkg::*;

    typedef longint unsigned t_u64;

    // The index field is wider than the register list; this one selects nothing.
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNUSED = 3'd7;

    localparam logic signed [COORD_WIDTH-1:0] C_MAX = 16'sh7fff;
    localparam logic signed [COORD_WIDTH-1:0] C_MIN = 16'sh8000;
    localparam logic [SCALE_WIDTH-1:0]        SCALE_ONE = 16'd4096;
    localparam int                            PIPE_LATENCY = 4;

    localparam logic [6*COORD_WIDTH-1:0] EDGE_VERTS =
        {C_MAX, C_MIN, C_MIN, C_MAX, 16'sd1, -16'sd1};
    localparam logic [6*COORD_WIDTH-1:0] CORNER_VERTS =
        {C_MAX, C_MIN, 16'sd0, 16'sd0, C_MIN, C_MAX};
    localparam logic [6*COORD_WIDTH-1:0] QUARTER_VERTS =
        {16'sd0, C_MIN, 16'sd100, 16'sd200, C_MIN, 16'sd0};
    localparam logic [6*COORD_WIDTH-1:0] STRETCH_VERTS =
        {16'sd1, 16'sd5, -16'sd1, -16'sd7, C_MAX, 16'sd0};
    localparam logic [6*COORD_WIDTH-1:0] PLAIN_VERTS =
        {16'sd1234, -16'sd4321, -16'sd30000, 16'sd30000, 16'sd5, -16'sd5};
    localparam logic [6*COORD_WIDTH-1:0] SMALL_VERTS =
        {16'sd1000, -16'sd2000, 16'sd3, 16'sd4, -16'sd7, 16'sd9};

    typedef enum bit {
        ROW_WRITE,
        ROW_REQUEST
    } t_row_kind;

    typedef struct packed {
        t_row_kind                  kind;
        logic [CFG_INDEX_WIDTH-1:0] index;
        logic [CFG_DATA_WIDTH-1:0]  value;
        t_in_payload                item;
        bit                         typed;
        t_out_payload               outcome;
    } t_dir_row;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [CFG_INDEX_WIDTH-1:0] i_cfg_index;
    logic [CFG_DATA_WIDTH-1:0]  i_cfg_data;

    taf_in_if  req_if ();
    taf_out_if res_if ();

    triangle_affine_transform_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (req_if),
        .o_res       (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the configuration registers.
    logic signed [COORD_WIDTH-1:0] cfg_shift_x;
    logic signed [COORD_WIDTH-1:0] cfg_shift_y;
    logic signed [COORD_WIDTH-1:0] cfg_pivot_x;
    logic signed [COORD_WIDTH-1:0] cfg_pivot_y;
    logic [ANGLE_WIDTH-1:0]        cfg_angle;
    logic [SCALE_WIDTH-1:0]        cfg_scale_x;
    logic [SCALE_WIDTH-1:0]        cfg_scale_y;

    t_out_payload expected_triangles[$];
    t_dir_row     directed_rows[$];
    int           error_count = 0;
    int           send_idle_pct = 0;
    int           recv_stall_pct = 0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

    // Quarter-wave sine of a whole-degree angle, series evaluated in Q2.30.
    function automatic longint quarter_sine(int deg);
        longint unsigned arg;
        longint unsigned arg_sq;
        longint unsigned term;
        longint          acc;
        arg    = (t_u64'(deg) * PI_Q30 + t_u64'(QUARTER_TURN))
                 / t_u64'(HALF_TURN);
        arg_sq = (arg * arg) >> 30;
        term   = arg;
        acc    = longint'(arg);
        for (int k = 1; k <= 10; k++) begin
            term = ((term * arg_sq) >> 30) / t_u64'((2 * k) * (2 * k + 1));
            if (k % 2 == 1) begin
                acc = acc - longint'(term);
            end else begin
                acc = acc + longint'(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        if (acc > (64'sd1 <<< 30)) begin
            acc = 64'sd1 <<< 30;
        end
        return (acc + (64'sd1 <<< (29 - TRIG_FRACTION_BITS))) >>> (30 - TRIG_FRACTION_BITS);
    endfunction

    function automatic logic signed [COORD_WIDTH-1:0] clamp_coord(longint v,
                                                                 inout logic clamped);
        if (v > C_MAX) begin
            clamped = 1'b1;
            return C_MAX;
        end else if (v < C_MIN) begin
            clamped = 1'b1;
            return C_MIN;
        end
        return v[COORD_WIDTH-1:0];
    endfunction

    function automatic t_out_payload predict_triangle(t_in_payload item);
        longint                        in_x [NUM_LANES];
        longint                        in_y [NUM_LANES];
        logic signed [COORD_WIDTH-1:0] res_x [NUM_LANES];
        logic signed [COORD_WIDTH-1:0] res_y [NUM_LANES];
        longint                        new_x;
        longint                        new_y;
        longint                        dx;
        longint                        dy;
        longint                        px;
        longint                        py;
        longint                        sn;
        longint                        cs;
        longint                        trig_one;
        longint                        scale_unit;
        int                            deg;
        logic                          clamped;
        in_x[0]    = longint'(item.vertex_a_x);
        in_y[0]    = longint'(item.vertex_a_y);
        in_x[1]    = longint'(item.vertex_b_x);
        in_y[1]    = longint'(item.vertex_b_y);
        in_x[2]    = longint'(item.vertex_c_x);
        in_y[2]    = longint'(item.vertex_c_y);
        px         = longint'(cfg_pivot_x);
        py         = longint'(cfg_pivot_y);
        trig_one   = 64'sd1 <<< TRIG_FRACTION_BITS;
        scale_unit = 64'sd1 <<< SCALE_FRACTION_BITS;
        clamped    = 1'b0;

        deg = int'(cfg_angle);
        if (deg >= FULL_TURN) begin
            deg = deg - FULL_TURN;
        end
        if (deg < QUARTER_TURN) begin
            sn = quarter_sine(deg);
            cs = quarter_sine(QUARTER_TURN - deg);
        end else if (deg < HALF_TURN) begin
            sn = quarter_sine(HALF_TURN - deg);
            cs = -quarter_sine(deg - QUARTER_TURN);
        end else if (deg < THREE_QUARTER_TURN) begin
            sn = -quarter_sine(deg - HALF_TURN);
            cs = -quarter_sine(THREE_QUARTER_TURN - deg);
        end else begin
            sn = -quarter_sine(FULL_TURN - deg);
            cs = quarter_sine(deg - THREE_QUARTER_TURN);
        end

        for (int v = 0; v < NUM_LANES; v++) begin
            dx = in_x[v] - px;
            dy = in_y[v] - py;
            case (item.opcode)
                OP_TRANSLATE: begin
                    new_x = in_x[v] + longint'(cfg_shift_x);
                    new_y = in_y[v] + longint'(cfg_shift_y);
                end
                OP_ROTATE: begin
                    new_x = (px * trig_one + dx * cs - dy * sn) / trig_one;
                    new_y = (py * trig_one + dx * sn + dy * cs) / trig_one;
                end
                OP_SCALE: begin
                    new_x = (px * scale_unit + dx * longint'(cfg_scale_x)) / scale_unit;
                    new_y = (py * scale_unit + dy * longint'(cfg_scale_y)) / scale_unit;
                end
                default: begin
                    new_x = in_x[v];
                    new_y = in_y[v];
                end
            endcase
            res_x[v] = clamp_coord(new_x, clamped);
            res_y[v] = clamp_coord(new_y, clamped);
        end
        return {res_x[0], res_y[0], res_x[1], res_y[1], res_x[2], res_y[2], clamped};
    endfunction

    task automatic check_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    task automatic check_triangle(t_out_payload got);
        t_out_payload want;
        if (expected_triangles.size() == 0) begin
            $error("result arrived with no request outstanding");
            error_count++;
        end else begin
            want = expected_triangles.pop_front();
            check_field("out_a_x", want.out_a_x, got.out_a_x);
            check_field("out_a_y", want.out_a_y, got.out_a_y);
            check_field("out_b_x", want.out_b_x, got.out_b_x);
            check_field("out_b_y", want.out_b_y, got.out_b_y);
            check_field("out_c_x", want.out_c_x, got.out_c_x);
            check_field("out_c_y", want.out_c_y, got.out_c_y);
            check_field("saturated", want.saturated, got.saturated);
        end
    endtask

    // Result side: ready is redrawn every cycle, results are taken at the rising edge.
    initial begin
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            res_if.ready <= ($urandom_range(99) >= recv_stall_pct);
            @(posedge i_clk);
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                check_triangle(res_if.data);
            end
        end
    end

    task automatic send_request(t_in_payload item, t_out_payload outcome);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        req_if.valid <= 1'b1;
        req_if.data  <= item;
        do begin
            @(posedge i_clk);
        end while (req_if.ready !== 1'b1);
        expected_triangles.push_back(outcome);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        req_if.valid <= 1'b0;
        while (expected_triangles.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_WIDTH-1:0] index,
                             logic [CFG_DATA_WIDTH-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= index;
        i_cfg_data  <= value;
        case (index)
            REG_SHIFT_X: cfg_shift_x = value;
            REG_SHIFT_Y: cfg_shift_y = value;
            REG_ANGLE:   cfg_angle   = value[ANGLE_WIDTH-1:0];
            REG_PIVOT_X: cfg_pivot_x = value;
            REG_PIVOT_Y: cfg_pivot_y = value;
            REG_SCALE_X: cfg_scale_x = value;
            REG_SCALE_Y: cfg_scale_y = value;
            default: ;
        endcase
    endtask

    task automatic end_writes();
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [COORD_WIDTH-1:0] rand_coord();
        case ($urandom_range(7))
            0:       return C_MIN;
            1:       return C_MAX;
            2:       return COORD_WIDTH'($urandom_range(200)) - 16'sd100;
            default: return COORD_WIDTH'($urandom);
        endcase
    endfunction

    function automatic logic [SCALE_WIDTH-1:0] rand_scale();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return SCALE_ONE;
            3:       return SCALE_WIDTH'($urandom_range(8192));
            default: return SCALE_WIDTH'($urandom);
        endcase
    endfunction

    task automatic write_random_settings();
        logic [CFG_DATA_WIDTH-1:0] angle_word;
        wait_idle();
        // Upper bits of the angle write lie outside the register and are dropped.
        angle_word = CFG_DATA_WIDTH'($urandom);
        case ($urandom_range(5))
            0:       angle_word[ANGLE_WIDTH-1:0] = '0;
            1:       angle_word[ANGLE_WIDTH-1:0] = ANGLE_WIDTH'(FULL_TURN - 1);
            2:       angle_word[ANGLE_WIDTH-1:0] = ANGLE_WIDTH'(FULL_TURN);
            3:       angle_word[ANGLE_WIDTH-1:0] = '1;
            default: angle_word[ANGLE_WIDTH-1:0] = ANGLE_WIDTH'($urandom_range(359));
        endcase
        write_reg(REG_SHIFT_X, rand_coord());
        write_reg(REG_SHIFT_Y, rand_coord());
        write_reg(REG_ANGLE, angle_word);
        write_reg(REG_PIVOT_X, rand_coord());
        write_reg(REG_PIVOT_Y, rand_coord());
        write_reg(REG_SCALE_X, rand_scale());
        write_reg(REG_SCALE_Y, rand_scale());
        if ($urandom_range(3) == 0) begin
            write_reg(REG_UNUSED, CFG_DATA_WIDTH'($urandom));
        end
        end_writes();
    endtask

    initial begin
        t_in_payload item;
        t_dir_row    row;
        bit          writing;
        int          op_pick;

        i_rst_n      = 1'b0;
        i_cfg_we     = 1'b0;
        i_cfg_index  = '0;
        i_cfg_data   = '0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        cfg_shift_x  = '0;
        cfg_shift_y  = '0;
        cfg_angle    = '0;
        cfg_pivot_x  = '0;
        cfg_pivot_y  = '0;
        cfg_scale_x  = SCALE_ONE;
        cfg_scale_y  = SCALE_ONE;

        // Out of reset every transform is the identity.
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_TRANSLATE, 96'd0}, 1'b1, 97'd0});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_TRANSLATE, EDGE_VERTS}, 1'b1,
                                  {EDGE_VERTS, 1'b0}});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_ROTATE, EDGE_VERTS}, 1'b1,
                                  {EDGE_VERTS, 1'b0}});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_SCALE, EDGE_VERTS}, 1'b1,
                                  {EDGE_VERTS, 1'b0}});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_PASS, EDGE_VERTS}, 1'b1,
                                  {EDGE_VERTS, 1'b0}});
        // Shifts at both ends of the range drive the first corner vertex into the clamp.
        directed_rows.push_back('{ROW_WRITE, REG_SHIFT_X, C_MAX, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_WRITE, REG_SHIFT_Y, C_MIN, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_TRANSLATE, CORNER_VERTS}, 1'b1,
                                  {C_MAX, C_MIN, C_MAX, C_MIN, -16'sd1, -16'sd1, 1'b1}});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_PASS, CORNER_VERTS}, 1'b1,
                                  {CORNER_VERTS, 1'b0}});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_TRANSLATE, PLAIN_VERTS}, 1'b0, '0});
        // A quarter turn maps (x, y) to (-y, x); an angle of 450 wraps to the same turn.
        directed_rows.push_back('{ROW_WRITE, REG_ANGLE, 16'(QUARTER_TURN), '0, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_ROTATE, QUARTER_VERTS}, 1'b1,
                                  {C_MAX, 16'sd0, -16'sd200, 16'sd100, 16'sd0, C_MIN, 1'b1}});
        directed_rows.push_back('{ROW_WRITE, REG_ANGLE, 16'(FULL_TURN + QUARTER_TURN),
                                  '0, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_ROTATE, QUARTER_VERTS}, 1'b1,
                                  {C_MAX, 16'sd0, -16'sd200, 16'sd100, 16'sd0, C_MIN, 1'b1}});
        directed_rows.push_back('{ROW_WRITE, REG_ANGLE, 16'(FULL_TURN - 1), '0, 1'b0, '0});
        directed_rows.push_back('{ROW_WRITE, REG_PIVOT_X, C_MIN, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_WRITE, REG_PIVOT_Y, C_MAX, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_ROTATE, EDGE_VERTS}, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_ROTATE, SMALL_VERTS}, 1'b0, '0});
        directed_rows.push_back('{ROW_WRITE, REG_ANGLE, 16'(HALF_TURN), '0, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_ROTATE, EDGE_VERTS}, 1'b0, '0});
        directed_rows.push_back('{ROW_WRITE, REG_ANGLE, 16'(THREE_QUARTER_TURN), '0, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_ROTATE, SMALL_VERTS}, 1'b0, '0});
        directed_rows.push_back('{ROW_WRITE, REG_ANGLE, 16'd45, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_ROTATE, PLAIN_VERTS}, 1'b0, '0});
        directed_rows.push_back('{ROW_WRITE, REG_ANGLE, 16'd511, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_ROTATE, CORNER_VERTS}, 1'b0, '0});
        // Largest x factor and a zero y factor about the origin.
        directed_rows.push_back('{ROW_WRITE, REG_PIVOT_X, 16'sd0, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_WRITE, REG_PIVOT_Y, 16'sd0, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_WRITE, REG_SCALE_X, 16'hffff, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_WRITE, REG_SCALE_Y, 16'h0000, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_SCALE, STRETCH_VERTS}, 1'b1,
                                  {16'sd15, 16'sd0, -16'sd15, 16'sd0, C_MAX, 16'sd0, 1'b1}});
        // A write past the last register must leave the scale untouched.
        directed_rows.push_back('{ROW_WRITE, REG_UNUSED, 16'hffff, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_SCALE, STRETCH_VERTS}, 1'b1,
                                  {16'sd15, 16'sd0, -16'sd15, 16'sd0, C_MAX, 16'sd0, 1'b1}});
        directed_rows.push_back('{ROW_WRITE, REG_SCALE_X, 16'h0000, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_WRITE, REG_SCALE_Y, 16'hffff, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_WRITE, REG_PIVOT_X, 16'sd100, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_WRITE, REG_PIVOT_Y, -16'sd100, '0, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_SCALE, EDGE_VERTS}, 1'b0, '0});
        directed_rows.push_back('{ROW_REQUEST, '0, '0, {OP_SCALE, SMALL_VERTS}, 1'b0, '0});

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        writing = 1'b0;
        foreach (directed_rows[n]) begin
            row = directed_rows[n];
            if (row.kind == ROW_WRITE) begin
                if (!writing) begin
                    wait_idle();
                end
                writing = 1'b1;
                write_reg(row.index, row.value);
            end else begin
                if (writing) begin
                    end_writes();
                end
                writing = 1'b0;
                send_request(row.item, row.typed ? row.outcome : predict_triangle(row.item));
            end
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    send_idle_pct  = 49;
                    recv_stall_pct = 0;
                end
                2: begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 49;
                end
                default: begin
                    send_idle_pct  = 30;
                    recv_stall_pct = 30;
                end
            endcase
            for (int setting = 0; setting < 2; setting++) begin
                write_random_settings();
                repeat (85) begin
                    op_pick           = $urandom_range(9);
                    item.opcode       = (op_pick == 0) ? OP_PASS : t_opcode'(op_pick % 3);
                    item.vertex_a_x   = rand_coord();
                    item.vertex_a_y   = rand_coord();
                    item.vertex_b_x   = rand_coord();
                    item.vertex_b_y   = rand_coord();
                    item.vertex_c_x   = rand_coord();
                    item.vertex_c_y   = rand_coord();
                    send_request(item, predict_triangle(item));
                end
            end
        end

        wait_idle();
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

[files.f]
src/taf_pkg.sv
src/taf_if.sv
src/taf_trig.sv
src/taf_lane.sv
src/triangle_affine_transform_top.sv
tb/tb_triangle_affine_transform_top.sv
